@@ design/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the burst-estimate priority scheduler.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int unsigned PRI_W   = 3;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned QUANT_W = 5;
  localparam int unsigned ALPHA_W = 9;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [CIDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BASE  = 2'd1;

  localparam logic [1:0] ST_OTHER   = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_WAITING = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd243;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic signed [PRI_W-1:0] BASE_RESET = 3'sd1;

  localparam logic [BURST_W-1:0] EST_RESET   = 16'd5;
  localparam logic [QUANT_W-1:0] QUANT_RESET = 5'd20;

  // timer-expiry bands (estimate above threshold)
  localparam logic [BURST_W-1:0] EXP_HI  = 16'd25;
  localparam logic [BURST_W-1:0] EXP_MID = 16'd21;
  localparam logic [BURST_W-1:0] EXP_LO  = 16'd17;
  // I/O-return bands (estimate below threshold)
  localparam logic [BURST_W-1:0] IO_LO   = 16'd6;
  localparam logic [BURST_W-1:0] IO_HI   = 16'd11;

  localparam logic [QUANT_W-1:0] Q_BAND0 = 5'd10;
  localparam logic [QUANT_W-1:0] Q_BAND1 = 5'd18;
  localparam logic [QUANT_W-1:0] Q_BAND2 = 5'd25;
  localparam logic [QUANT_W-1:0] Q_BAND3 = 5'd22;
  localparam logic [QUANT_W-1:0] Q_BAND4 = 5'd18;

  localparam logic signed [PRI_W-1:0] P_BAND0 = -3'sd1;
  localparam logic signed [PRI_W-1:0] P_BAND1 = 3'sd0;
  localparam logic signed [PRI_W-1:0] P_BAND2 = 3'sd1;
  localparam logic signed [PRI_W-1:0] P_BAND3 = 3'sd2;
  localparam logic signed [PRI_W-1:0] P_BAND4 = 3'sd3;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_EST   = 8'b0000_0010,
    S_BAND  = 8'b0000_0100,
    S_CMP   = 8'b0000_1000,
    S_PLACE = 8'b0001_0000,
    S_FRONT = 8'b0010_0000,
    S_POP   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

endpackage

@@ design/burst_estimate_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// burst_estimate_priority_scheduler
// Ready-queue scheduler with a shared exponentially averaged burst estimate.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_axis    in         tuser: operation; tdata: pid, status, never_ran, burst, pri, timer
// m_axis    out        tdata: assigned_pri, valid, pid, quantum, restart, drop, idle
// cfg       in         cfg_index_i, cfg_data_i (0 alpha weight, 1 first-run priority)
//
// One event at a time; input is ready only in S_IDLE. An insert passes S_EST, S_BAND,
// S_CMP once per RAM read and compare while walking from the tail (each shifted entry,
// plus the one that stops the walk; none on an empty queue), S_PLACE and S_DONE; a dropped
// insert skips S_CMP and S_PLACE. Dispatch: CPU idle S_FRONT, S_POP, S_DONE (no S_POP
// on an empty queue); busy, no expiry S_DONE; with expiry the reinsert, then as idle.
// The queue is a circular buffer in RAM; no clearing pass after reset.
// Results go to an output register; while it stalls, the next result waits in S_DONE.
module burst_estimate_priority_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned PID_BITS    = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic                   s_axis_tuser,   // operation
  // pid, status[2], never_ran, last_burst[16], current_priority[3], timer_expired
  input  logic [((PID_BITS+23+7)/8)*8-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // assigned_priority[3], dispatched_valid, dispatched_pid, quantum[5],
  // timer_restart, queue_full_drop, idle
  output logic [((PID_BITS+14+7)/8)*8-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [bsp_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [bsp_pkg::ALPHA_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH > 1 ? QUEUE_DEPTH : 2);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W = PID_BITS + bsp_pkg::PRI_W;
  localparam int unsigned OUT_W = ((PID_BITS + 14 + 7) / 8) * 8;
  localparam int unsigned PROD_W = 25;
  localparam int unsigned SUM_W  = 26;

  typedef logic signed [bsp_pkg::PRI_W-1:0] pri_t;

  bsp_pkg::state_e state_q, state_d;

  logic [bsp_pkg::ALPHA_W-1:0] alpha_q;
  pri_t                        base_q;
  logic [bsp_pkg::BURST_W-1:0] est_q, est_d;
  logic [bsp_pkg::QUANT_W-1:0] qv_q, qv_d;
  logic                        busy_q, busy_d;
  logic [PID_BITS-1:0]         run_q, run_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [IDX_W-1:0]            head_q, head_d;
  logic [CNT_W-1:0]            k_q, k_d;

  // event fields
  logic                        disp_q, disp_d;
  logic [PID_BITS-1:0]         pid_q, pid_d;
  logic [1:0]                  stat_q, stat_d;
  logic                        timer_q, timer_d;
  logic                        burst_nz_q, burst_nz_d;
  pri_t                        pri_q, pri_d;
  logic [PROD_W-1:0]           prod_q, prod_d;
  logic [bsp_pkg::ALPHA_W-1:0] w_q, w_d;

  // result
  pri_t                        r_pri_q, r_pri_d;
  logic                        r_val_q, r_val_d;
  logic [PID_BITS-1:0]         r_pid_q, r_pid_d;
  logic [bsp_pkg::QUANT_W-1:0] r_qnt_q, r_qnt_d;
  logic                        r_rst_q, r_rst_d;
  logic                        r_drop_q, r_drop_d;
  logic                        r_idle_q, r_idle_d;
  logic                        ovld_q, ovld_d;
  logic [OUT_W-1:0]            out_q;

  logic                        we;
  logic [IDX_W-1:0]            waddr, raddr;
  logic [ENT_W-1:0]            wdata, rdata;
  pri_t                        rd_pri;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                            input logic [CNT_W-1:0] k);
    logic [CNT_W+1:0] s;
    s = (CNT_W+2)'(h) + (CNT_W+2)'(k);
    if (s >= (CNT_W+2)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+2)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  bsp_ram #(.WIDTH(ENT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_pri        = rdata[bsp_pkg::PRI_W-1:0];
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == bsp_pkg::S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    logic [SUM_W-1:0]            sum;
    logic [bsp_pkg::ALPHA_W:0]   wc;
    logic [bsp_pkg::ALPHA_W-1:0] wsat;
    logic                        ins;
    logic [1:0]                  st;
    pri_t                        p;
    state_d = state_q;
    est_d = est_q;   qv_d = qv_q;   busy_d = busy_q;  run_d = run_q;
    count_d = count_q; head_d = head_q; k_d = k_q;
    disp_d = disp_q; pid_d = pid_q; stat_d = stat_q; timer_d = timer_q;
    burst_nz_d = burst_nz_q; pri_d = pri_q; prod_d = prod_q; w_d = w_q;
    r_pri_d = r_pri_q; r_val_d = r_val_q; r_pid_d = r_pid_q; r_qnt_d = r_qnt_q;
    r_rst_d = r_rst_q; r_drop_d = r_drop_q; r_idle_d = r_idle_q;
    ovld_d = ovld_q && !m_axis_tready;
    we = 1'b0;
    waddr = phys(head_q, k_q);
    wdata = {pid_q, pri_q};
    raddr = head_q;
    sum = '0;
    wc = '0;
    wsat = (alpha_q > bsp_pkg::ALPHA_ONE) ? bsp_pkg::ALPHA_ONE : alpha_q;
    ins = 1'b0;
    st = 2'd0;
    p = '0;

    case (state_q)
      bsp_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          st = s_axis_tdata[PID_BITS +: 2];
          if (st == 2'd3) begin
            st = bsp_pkg::ST_OTHER;
          end
          p = s_axis_tdata[PID_BITS+19 +: 3];
          if (s_axis_tdata[PID_BITS+2]) begin
            p = base_q;
          end
          disp_d = s_axis_tuser;
          ins = !s_axis_tuser || (busy_q && s_axis_tdata[PID_BITS+22]);
          pid_d = s_axis_tuser ? run_q : s_axis_tdata[PID_BITS-1:0];
          stat_d = s_axis_tuser ? bsp_pkg::ST_RUNNING : st;
          timer_d = s_axis_tuser ? 1'b1 : s_axis_tdata[PID_BITS+22];
          burst_nz_d = (s_axis_tdata[PID_BITS+3 +: 16] != '0);
          pri_d = p;
          w_d = wsat;
          prod_d = PROD_W'(wsat) * PROD_W'(s_axis_tdata[PID_BITS+3 +: 16]);
          r_pri_d = '0; r_val_d = 1'b0; r_pid_d = '0; r_qnt_d = '0;
          r_rst_d = 1'b0; r_drop_d = 1'b0; r_idle_d = 1'b0;
          if (ins) begin
            state_d = bsp_pkg::S_EST;
          end else if (s_axis_tuser && busy_q) begin
            r_val_d = 1'b1;
            r_pid_d = run_q;
            r_qnt_d = qv_q;
            state_d = bsp_pkg::S_DONE;
          end else begin
            state_d = bsp_pkg::S_FRONT;
          end
        end
      end
      bsp_pkg::S_EST: begin
        wc = (bsp_pkg::ALPHA_W+1)'(bsp_pkg::ALPHA_ONE) - (bsp_pkg::ALPHA_W+1)'(w_q);
        sum = SUM_W'(prod_q) + SUM_W'(wc) * SUM_W'(est_q) + SUM_W'(255);
        if (burst_nz_q && ((stat_q == bsp_pkg::ST_RUNNING && timer_q) ||
                           stat_q == bsp_pkg::ST_WAITING)) begin
          est_d = sum[8 +: bsp_pkg::BURST_W];
        end
        state_d = bsp_pkg::S_BAND;
      end
      bsp_pkg::S_BAND: begin
        p = pri_q;
        if (stat_q == bsp_pkg::ST_RUNNING && timer_q) begin
          if (est_q > bsp_pkg::EXP_HI) begin
            qv_d = bsp_pkg::Q_BAND4; p = bsp_pkg::P_BAND4;
          end else if (est_q > bsp_pkg::EXP_MID) begin
            qv_d = bsp_pkg::Q_BAND3; p = bsp_pkg::P_BAND3;
          end else if (est_q > bsp_pkg::EXP_LO) begin
            qv_d = bsp_pkg::Q_BAND2; p = bsp_pkg::P_BAND2;
          end else if (p < bsp_pkg::P_BAND4) begin
            p = p + 3'sd1;
          end
        end else if (stat_q == bsp_pkg::ST_WAITING) begin
          if (est_q < bsp_pkg::IO_LO) begin
            qv_d = bsp_pkg::Q_BAND1; p = bsp_pkg::P_BAND0;
          end else if (est_q < bsp_pkg::IO_HI) begin
            qv_d = bsp_pkg::Q_BAND0; p = bsp_pkg::P_BAND1;
          end else if (p > bsp_pkg::P_BAND0) begin
            p = p - 3'sd1;
          end
        end
        pri_d = p;
        r_pri_d = p;
        k_d = count_q;
        if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
          r_drop_d = 1'b1;
          state_d = disp_q ? bsp_pkg::S_FRONT : bsp_pkg::S_DONE;
        end else if (count_q == '0) begin
          state_d = bsp_pkg::S_PLACE;
        end else begin
          raddr = phys(head_q, count_q - CNT_W'(1));
          state_d = bsp_pkg::S_CMP;
        end
      end
      bsp_pkg::S_CMP: begin
        // shift the tail entry up while it ranks behind the new one
        if (rd_pri > pri_q) begin
          we = 1'b1;
          wdata = rdata;
          k_d = k_q - CNT_W'(1);
          if (k_q == CNT_W'(1)) begin
            state_d = bsp_pkg::S_PLACE;
          end else begin
            raddr = phys(head_q, k_q - CNT_W'(2));
          end
        end else begin
          state_d = bsp_pkg::S_PLACE;
        end
      end
      bsp_pkg::S_PLACE: begin
        we = 1'b1;
        count_d = count_q + CNT_W'(1);
        state_d = disp_q ? bsp_pkg::S_FRONT : bsp_pkg::S_DONE;
      end
      bsp_pkg::S_FRONT: begin
        raddr = head_q;
        if (count_q == '0) begin
          busy_d = 1'b0;
          r_idle_d = 1'b1;
          state_d = bsp_pkg::S_DONE;
        end else begin
          state_d = bsp_pkg::S_POP;
        end
      end
      bsp_pkg::S_POP: begin
        run_d = rdata[bsp_pkg::PRI_W +: PID_BITS];
        head_d = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
        count_d = count_q - CNT_W'(1);
        busy_d = 1'b1;
        r_val_d = 1'b1;
        r_pid_d = rdata[bsp_pkg::PRI_W +: PID_BITS];
        r_qnt_d = qv_q;
        r_rst_d = 1'b1;
        state_d = bsp_pkg::S_DONE;
      end
      bsp_pkg::S_DONE: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d = 1'b1;
          state_d = bsp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bsp_pkg::S_IDLE;
      end
    endcase
  end

  // in S_DONE the result registers hold the new result while out_q drains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsp_pkg::S_IDLE;
      alpha_q <= bsp_pkg::ALPHA_RESET;
      base_q  <= bsp_pkg::BASE_RESET;
      est_q   <= bsp_pkg::EST_RESET;
      qv_q    <= bsp_pkg::QUANT_RESET;
      busy_q  <= 1'b0;
      run_q   <= '0;
      count_q <= '0;
      head_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      est_q   <= est_d;
      qv_q    <= qv_d;
      busy_q  <= busy_d;
      run_q   <= run_d;
      count_q <= count_d;
      head_q  <= head_d;
      ovld_q  <= ovld_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == bsp_pkg::CFG_ALPHA) begin
          alpha_q <= cfg_data_i;
        end else if (cfg_index_i == bsp_pkg::CFG_BASE) begin
          base_q <= cfg_data_i[bsp_pkg::PRI_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    disp_q <= disp_d;  pid_q <= pid_d;  stat_q <= stat_d;  timer_q <= timer_d;
    burst_nz_q <= burst_nz_d;  pri_q <= pri_d;  prod_q <= prod_d;  w_q <= w_d;
    r_pri_q <= r_pri_d;  r_val_q <= r_val_d;  r_pid_q <= r_pid_d;
    r_qnt_q <= r_qnt_d;  r_rst_q <= r_rst_d;  r_drop_q <= r_drop_d;
    r_idle_q <= r_idle_d;
    // keep the delivered result stable until it is taken
    if (state_q == bsp_pkg::S_DONE && (!ovld_q || m_axis_tready)) begin
      out_q <= OUT_W'({r_idle_q, r_drop_q, r_rst_q, r_qnt_q, r_pid_q, r_val_q, r_pri_q});
    end
  end

endmodule

@@ design/bsp_ram.sv @@
// ----------------------------------------------------------------------------
// bsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsp_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/bsp_checker.sv @@
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks of the burst-estimate priority scheduler.
// ----------------------------------------------------------------------------
module bsp_checker #(
  parameter int unsigned PID_BITS = 8
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [((PID_BITS+14+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int unsigned VAL_B  = 3;
  localparam int unsigned RST_B  = PID_BITS + 9;
  localparam int unsigned DROP_B = PID_BITS + 10;
  localparam int unsigned IDLE_B = PID_BITS + 11;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

  a_idle_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[VAL_B] && m_axis_tdata[IDLE_B]))
    else $error("dispatch both valid and idle");

  a_drop_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[DROP_B] |-> !m_axis_tdata[IDLE_B])
    else $error("full queue reported idle");

  a_restart_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[RST_B] |-> m_axis_tdata[VAL_B])
    else $error("timer restart without dispatch");

endmodule

bind burst_estimate_priority_scheduler bsp_checker #(.PID_BITS(PID_BITS)) u_bsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/burst_estimate_priority_scheduler_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// burst_estimate_priority_scheduler_tb
// Self-checking bench: directed table plus random inserts and dispatches, each
// result checked against a known table row or a model of queue, estimate, CPU.
// ----------------------------------------------------------------------------
module burst_estimate_priority_scheduler_tb;

  localparam int QDEPTH = 16;
  localparam int IN_W  = 32;
  localparam int OUT_W = 24;
  localparam int WDOG_LIMIT = 20000;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef struct packed {
    logic              op;
    logic [7:0]        pid;
    logic [1:0]        status;
    logic              never_ran;
    logic [15:0]       burst;
    logic signed [2:0] pri;
    logic              timer;
  } event_t;

  typedef struct packed {
    logic signed [2:0] pri;
    logic              valid;
    logic [7:0]        pid;
    logic [4:0]        quant;
    logic              restart;
    logic              drop;
    logic              idle;
  } sched_t;

  typedef struct {
    event_t ev;
    logic   known;
    sched_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic s_axis_tuser = 1'b0;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [bsp_pkg::CIDX_W-1:0] cfg_index_i = '0;
  logic [bsp_pkg::ALPHA_W-1:0] cfg_data_i = '0;

  burst_estimate_priority_scheduler u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // scheduler model state
  logic [7:0]        q_pid [QDEPTH];
  logic signed [3:0] q_pri [QDEPTH];
  int                q_count;
  logic [15:0]       est;
  logic [4:0]        quant_cur;
  logic              busy;
  logic [7:0]        run_pid;
  logic [8:0]        alpha;
  logic signed [2:0] base_pri;

  sched_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_idle = 0, n_drop = 0, n_restart = 0;
  int stall_req = 0;
  logic tx_done = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("ERROR t=%0t result %0d %s: got %0h expected %0h", $realtime, n_results,
             what, got, exp);
    errors++;
  endtask

  function automatic void model_reset();
    q_count = 0; est = bsp_pkg::EST_RESET; quant_cur = bsp_pkg::QUANT_RESET; busy = 0;
    run_pid = 0; alpha = bsp_pkg::ALPHA_RESET; base_pri = bsp_pkg::BASE_RESET;
  endfunction

  function automatic void update_est(input logic [15:0] b);
    logic [31:0] w, sum;
    if (b == 0) return;
    w = (alpha > 256) ? 256 : alpha;
    sum = w * b + (256 - w) * est;
    est = 16'((sum + 255) >> 8);
  endfunction

  function automatic logic enqueue(input logic [7:0] pid, input logic [1:0] st,
                                   input logic nr, input logic [15:0] b,
                                   input logic signed [2:0] pri_in, input logic tmr,
                                   output logic signed [2:0] assigned);
    logic signed [3:0] p;
    int pos;
    p = nr ? base_pri : pri_in;
    if (st == bsp_pkg::ST_RUNNING && tmr) begin
      update_est(b);
      if (est > 25) begin quant_cur = 18; p = 3; end
      else if (est > 21) begin quant_cur = 22; p = 2; end
      else if (est > 17) begin quant_cur = 25; p = 1; end
      else if (p < 3) p = p + 1;
    end else if (st == bsp_pkg::ST_WAITING) begin
      update_est(b);
      if (est < 6) begin quant_cur = 18; p = -1; end
      else if (est < 11) begin quant_cur = 10; p = 0; end
      else if (p > -1) p = p - 1;
    end
    // wraps like the 3-bit field
    assigned = p[2:0];
    p = 4'(signed'(p[2:0]));
    if (q_count >= QDEPTH) return 1'b1;
    pos = 0;
    while (pos < q_count && q_pri[pos] <= p) pos++;
    for (int k = q_count; k > pos; k--) begin
      q_pid[k] = q_pid[k-1]; q_pri[k] = q_pri[k-1];
    end
    q_pid[pos] = pid; q_pri[pos] = p;
    q_count++;
    return 1'b0;
  endfunction

  function automatic sched_t predict_schedule(input event_t ev);
    sched_t r;
    logic [1:0] st;
    logic front;
    r = '0;
    st = (ev.status == 2'd3) ? bsp_pkg::ST_OTHER : ev.status;
    if (ev.op == OP_INSERT) begin
      r.drop = enqueue(ev.pid, st, ev.never_ran, ev.burst, ev.pri, ev.timer, r.pri);
    end else begin
      front = 1;
      if (busy) begin
        if (ev.timer) r.drop = enqueue(run_pid, bsp_pkg::ST_RUNNING, ev.never_ran, ev.burst,
                                       ev.pri, 1'b1, r.pri);
        else begin
          front = 0; r.valid = 1; r.pid = run_pid; r.quant = quant_cur;
        end
      end
      if (front) begin
        if (q_count == 0) begin
          busy = 0; r.idle = 1;
        end else begin
          run_pid = q_pid[0];
          for (int k = 1; k < q_count; k++) begin
            q_pid[k-1] = q_pid[k]; q_pri[k-1] = q_pri[k];
          end
          q_count--;
          busy = 1; r.valid = 1; r.pid = run_pid; r.quant = quant_cur; r.restart = 1;
        end
      end
    end
    return r;
  endfunction

  // output side: checker
  always @(posedge clk_i) begin
    sched_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[11:4], m_axis_tdata[16:12],
             m_axis_tdata[17], m_axis_tdata[18], m_axis_tdata[19]};
      if (expected_q.size() == 0) begin
        report("unexpected result", m_axis_tdata, 0);
      end else begin
        exp = expected_q.pop_front();
        if (got.pri !== exp.pri) report("assigned_priority", got.pri, exp.pri);
        if (got.valid !== exp.valid) report("dispatched_valid", got.valid, exp.valid);
        if (got.pid !== exp.pid) report("dispatched_pid", got.pid, exp.pid);
        if (got.quant !== exp.quant) report("quantum", got.quant, exp.quant);
        if (got.restart !== exp.restart) report("timer_restart", got.restart, exp.restart);
        if (got.drop !== exp.drop) report("queue_full_drop", got.drop, exp.drop);
        if (got.idle !== exp.idle) report("idle", got.idle, exp.idle);
        n_idle += exp.idle; n_drop += exp.drop; n_restart += exp.restart;
      end
      n_results++;
    end
  end

  // receiver stall pattern; a long hold-off when requested
  always @(negedge clk_i) begin
    int hold;
    if (stall_req > 0) begin
      hold = stall_req;
      stall_req = 0;
      m_axis_tready <= 1'b0;
      repeat (hold) @(negedge clk_i);
    end
    case (n_results % 200 < 60 ? 0 : 1)
      0: m_axis_tready <= 1'b1;
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    int quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || stall_req > 0 || !rst_ni || tx_done)
      quiet = 0;
    else quiet++;
    if (quiet >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_event(input event_t ev, input logic known, input sched_t res);
    sched_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ev.op;
    s_axis_tdata  <= {1'b0, ev.timer, ev.pri, ev.burst, ev.never_ran, ev.status, ev.pid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_schedule(ev);
    expected_q.push_back(known ? res : pred);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (QDEPTH + 10) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [bsp_pkg::CIDX_W-1:0] idx,
                           input logic [bsp_pkg::ALPHA_W-1:0] val);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == bsp_pkg::CFG_ALPHA) alpha = val; else base_pri = val[2:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic event_t rand_event(input int mode);
    event_t ev;
    ev.op = $urandom_range(0, 99) < (mode == 0 ? 50 : 35) ? OP_DISPATCH : OP_INSERT;
    ev.pid = 8'($urandom);
    ev.status = 2'($urandom);
    ev.never_ran = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 4))
      0: ev.burst = '0;
      1: ev.burst = 16'($urandom_range(1, 40));
      2: ev.burst = 16'($urandom);
      default: ev.burst = 16'($urandom_range(0, 30));
    endcase
    ev.pri = $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(0, 4) - 1);
    ev.timer = 1'($urandom);
    return ev;
  endfunction

  row_t dir_rows[$];

  function automatic event_t mk(input logic op, input logic [7:0] pid, input logic [1:0] st,
                                input logic nr, input logic [15:0] b,
                                input logic signed [2:0] p, input logic t);
    event_t ev;
    ev.op = op; ev.pid = pid; ev.status = st; ev.never_ran = nr; ev.burst = b;
    ev.pri = p; ev.timer = t;
    return ev;
  endfunction

  initial begin
    sched_t r0;
    int burst_len;
    model_reset();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // after reset: dispatch on an empty queue is idle
    r0 = '0; r0.idle = 1;
    dir_rows.push_back('{mk(OP_DISPATCH, 8'h00, 0, 0, 0, 0, 0), 1'b1, r0});
    // insert of a new process, never ran: first-run priority 1
    r0 = '0; r0.pri = 3'sd1;
    dir_rows.push_back('{mk(OP_INSERT, 8'hFF, bsp_pkg::ST_OTHER, 1, 16'hFFFF, 3'sd3, 1),
                         1'b1, r0});
    dir_rows.push_back('{mk(OP_INSERT, 8'h01, bsp_pkg::ST_WAITING, 0, 16'd3, -3'sd1, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk(OP_INSERT, 8'h02, bsp_pkg::ST_RUNNING, 0, 16'd60, 3'sd0, 1),
                         1'b0, '0});
    dir_rows.push_back('{mk(OP_INSERT, 8'h03, bsp_pkg::ST_RUNNING, 0, 16'd9, 3'sd2, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk(OP_INSERT, 8'h04, 2'd3, 0, 16'd0, -3'sd4, 1), 1'b0, '0});
    dir_rows.push_back('{mk(OP_INSERT, 8'h05, bsp_pkg::ST_WAITING, 0, 16'hFFFF, 3'sd3, 1),
                         1'b0, '0});
    dir_rows.push_back('{mk(OP_INSERT, 8'h06, bsp_pkg::ST_RUNNING, 0, 16'd20, 3'sd2, 1),
                         1'b0, '0});
    dir_rows.push_back('{mk(OP_INSERT, 8'h07, bsp_pkg::ST_WAITING, 0, 16'd8, 3'sd1, 0),
                         1'b0, '0});
    dir_rows.push_back('{mk(OP_DISPATCH, 8'h00, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_DISPATCH, 8'h00, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk(OP_DISPATCH, 8'h00, 0, 0, 16'd30, 3'sd1, 1), 1'b0, '0});
    dir_rows.push_back('{mk(OP_DISPATCH, 8'h00, 0, 1, 16'd0, 3'sd0, 1), 1'b0, '0});
    for (int i = 0; i < 16; i++)
      dir_rows.push_back('{mk(OP_INSERT, 8'(8'h80 + i), bsp_pkg::ST_OTHER, 0, 0,
                              3'(i % 5 - 1), 0), 1'b0, '0});
    foreach (dir_rows[i]) send_event(dir_rows[i].ev, dir_rows[i].known, dir_rows[i].res);
    // rotate the full queue through expiring dispatches
    for (int i = 0; i < 20; i++) send_event(mk(OP_DISPATCH, 0, 0, 0, 0, 0, 1), 1'b0, '0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(bsp_pkg::CFG_ALPHA, 9'd0);   write_reg(bsp_pkg::CFG_BASE, 9'h7);
        end
        1: begin
          write_reg(bsp_pkg::CFG_ALPHA, 9'd256); write_reg(bsp_pkg::CFG_BASE, 9'd3);
        end
        2: begin
          write_reg(bsp_pkg::CFG_ALPHA, 9'h1FF); write_reg(bsp_pkg::CFG_BASE, 9'h1FC);
        end
        3: begin
          write_reg(bsp_pkg::CFG_ALPHA, 9'd128); write_reg(bsp_pkg::CFG_BASE, 9'd0);
        end
        default: begin
          write_reg(bsp_pkg::CFG_ALPHA, 9'd243); write_reg(bsp_pkg::CFG_BASE, 9'd1);
        end
      endcase
      for (int n = 0; n < 160; ) begin
        if (ph == 1 && n == 40) stall_req = 300;
        burst_len = $urandom_range(1, 12);
        for (int k = 0; k < burst_len && n < 160; k++, n++)
          send_event(rand_event(ph % 2), 1'b0, '0);
        idle_input();
        if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 20)) @(negedge clk_i);
      end
      drain();
    end

    tx_done = 1'b1;
    $display("Covered %0d results: %0d idle dispatches, %0d dropped inserts, %0d restarts,",
             n_results, n_idle, n_drop, n_restart);
    $display("over five weight/first-run-priority settings including both extremes.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
